FILE: rtl/fcsg_pkg.sv
package fcsg_pkg;

	// radius field width on the input stream
	localparam int RAD_W = 6;
	// cap on span beats per circle
	localparam int MAX_RESULTS = 48;
	localparam int CNT_W = $clog2(MAX_RESULTS);

	// controller -> datapath
	typedef struct packed {
		logic load;   // take a new circle from the input beat
		logic step;   // register one span set and advance the walk
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // output register can take a beat this cycle
		logic is_last;    // current iteration is the final one of the circle
	} sts_t;

endpackage

FILE: rtl/fcsg_ctrl.sv
module fcsg_ctrl import fcsg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t state_q, state_d;

	// handshake and commands
	assign s_tready = (state_q == ST_IDLE);
	assign cmd.load = s_tvalid && s_tready;
	assign cmd.step = (state_q == ST_WALK) && sts.out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (cmd.step && sts.is_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_load_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_WALK))
		else $error("walk did not start after a circle was taken");
	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && sts.is_last |=> s_tready)
		else $error("input not ready after the last span set");
	a_load_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load and step in the same cycle");
`endif

endmodule

FILE: rtl/fcsg_datapath.sv
module fcsg_datapath import fcsg_pkg::*; #(
	parameter int COORD_BITS = 13,
	parameter int RADIUS_MAX = 63
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cmd_t                        cmd,
	output sts_t                        sts,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [RAD_W-1:0]            radius,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [8*(COORD_BITS+1)-1:0] m_tdata,
	output logic                        m_tlast
);

	localparam int OUT_W = COORD_BITS + 1;
	localparam int RAD_TOP = (1 << RAD_W) - 1;
	localparam int RAD_CAP = (RADIUS_MAX > RAD_TOP) ? RAD_TOP : RADIUS_MAX;

	// walk state
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic [RAD_W-1:0]             rad_q;
	logic [6:0]                   col_q;
	logic signed [7:0]            row_q;
	logic signed [8:0]            dec_q;
	logic [CNT_W-1:0]             cnt_q;

	// output stage
	logic [8*OUT_W-1:0] tdata_q;
	logic               tlast_q;
	logic               tvalid_q;

	// radius clamp
	logic [RAD_W-1:0] rad_sat;
	assign rad_sat = (radius > RAD_W'(RAD_CAP)) ? RAD_W'(RAD_CAP) : radius;

	// decision tests and updates
	logic signed [7:0] rdiff, rc;
	logic signed [8:0] two_col, two_rdiff, col2p1, row2m1, two_rc;
	logic              d_ge, d_lt;
	logic signed [8:0] dec_n;
	logic signed [7:0] row_n;
	logic [6:0]        col_n;
	logic              stop_n;

	always_comb begin
		two_col   = $signed({1'b0, col_q, 1'b0});
		rdiff     = $signed({2'b00, rad_q}) - row_q;
		two_rdiff = $signed({rdiff, 1'b0});
		col2p1    = $signed({1'b0, col_q, 1'b1});
		row2m1    = $signed({row_q, 1'b0}) - 9'sd1;
		rc        = row_q - $signed({1'b0, col_q}) - 8'sd1;
		two_rc    = $signed({rc, 1'b0});
		d_ge      = dec_q >= two_col;
		d_lt      = dec_q < two_rdiff;
		if (d_ge) begin
			dec_n = dec_q - col2p1;
			row_n = row_q;
			col_n = col_q + 7'd1;
		end else if (d_lt) begin
			dec_n = dec_q + row2m1;
			row_n = row_q - 8'sd1;
			col_n = col_q;
		end else begin
			dec_n = dec_q + two_rc;
			row_n = row_q - 8'sd1;
			col_n = col_q + 7'd1;
		end
		stop_n = row_n < $signed({1'b0, col_n});
	end

	assign sts.is_last  = stop_n || (cnt_q == CNT_W'(MAX_RESULTS - 1));
	assign sts.out_free = !tvalid_q || m_tready;

	// span ends, wrapped to the output width
	logic signed [OUT_W-1:0] cx_e, cy_e, row_e, col_e;
	logic [8*OUT_W-1:0]      spans;

	always_comb begin
		cx_e  = OUT_W'(cx_q);
		cy_e  = OUT_W'(cy_q);
		row_e = OUT_W'(row_q);
		col_e = OUT_W'($signed({1'b0, col_q}));
		spans = {cy_e - row_e, cy_e + row_e, cx_e + col_e, cx_e - col_e,
		         cy_e - col_e, cy_e + col_e, cx_e + row_e, cx_e - row_e};
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q  <= center_x;
			cy_q  <= center_y;
			rad_q <= rad_sat;
			col_q <= '0;
			row_q <= $signed({2'b00, rad_sat});
			dec_q <= $signed({3'b000, rad_sat}) - 9'sd1;
			cnt_q <= '0;
		end else if (cmd.step) begin
			col_q <= col_n;
			row_q <= row_n;
			dec_q <= dec_n;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			tdata_q <= spans;
			tlast_q <= sts.is_last;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (cmd.step) begin
			tvalid_q <= 1'b1;
		end else if (m_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

`ifndef ASSERT_OFF
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (row_q >= $signed({1'b0, col_q})))
		else $error("span set emitted past the end of the walk");
	a_step_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> m_tvalid)
		else $error("stepped span set not presented");
	a_last_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && sts.is_last |=> m_tlast)
		else $error("final span set not flagged");
`endif

endmodule

FILE: rtl/filled_circle_span_generator.sv
// A taken circle loads the walk registers; steps then fill the output register.
// Throughput: one span beat per cycle while m_tready holds; a circle of radius r
// gives about r/sqrt(2)+1 beats (46 at radius 63), set by the one-step walk loop.
// A new circle is accepted the cycle after its predecessor's last beat is registered.
// Reset (arst_n low, asynchronous): controller idle, no beat valid; walk and
// payload registers are not reset.
module filled_circle_span_generator import fcsg_pkg::*; #(
	parameter int COORD_BITS = 13,
	parameter int RADIUS_MAX = 63
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// center_x, center_y, radius, zero fill
	input  logic [((2*COORD_BITS+RAD_W+7)/8)*8-1:0]     s_tdata,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// wide_left, wide_right, wide_row_low, wide_row_high,
	// narrow_left, narrow_right, narrow_row_low, narrow_row_high
	output logic [8*(COORD_BITS+1)-1:0]                 m_tdata,
	output logic                                        m_tlast
);

	cmd_t cmd;
	sts_t sts;

	logic signed [COORD_BITS-1:0] center_x, center_y;
	logic [RAD_W-1:0]             radius;

	// unpack the circle beat
	assign center_x = s_tdata[COORD_BITS-1:0];
	assign center_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign radius   = s_tdata[2*COORD_BITS+RAD_W-1:2*COORD_BITS];

	fcsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fcsg_datapath #(
		.COORD_BITS (COORD_BITS),
		.RADIUS_MAX (RADIUS_MAX)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
